[sv/vie_pkg.sv]
// Package of shared types and constants for the Vole instruction executor.
package vie_pkg;

  // Storage sizes and widths fixed by the instruction set.
  localparam int unsigned MEM_DEPTH_DEF = 256;
  localparam int unsigned REG_COUNT     = 16;
  localparam int unsigned DATA_W        = 8;
  localparam int unsigned RIDX_W        = 4;
  localparam int unsigned ADDR_W        = 8;
  localparam int unsigned INSTR_W       = 16;

  // Instruction opcodes; codes without a member are treated as bad opcodes.
  typedef enum logic [3:0] {
    OP_LOAD  = 4'h1,
    OP_LOADI = 4'h2,
    OP_STORE = 4'h3,
    OP_MOVE  = 4'h4,
    OP_ADD   = 4'h5,
    OP_FADD  = 4'h6,
    OP_OR    = 4'h7,
    OP_AND   = 4'h8,
    OP_XOR   = 4'h9,
    OP_ROT   = 4'hA,
    OP_JEQ   = 4'hB,
    OP_HALT  = 4'hC,
    OP_JGT   = 4'hD
  } opcode_e;

  // One result of an executed instruction.
  typedef struct packed {
    logic              halted;
    logic              jump_taken;
    logic [ADDR_W-1:0] jump_target;
    logic              screen_valid;
    logic [DATA_W-1:0] screen_value;
    logic              bad_opcode;
    logic              reg_written;
    logic [RIDX_W-1:0] reg_index;
    logic [DATA_W-1:0] reg_value;
  } result_t;

  // Register file write port.
  typedef struct packed {
    logic              en;
    logic [RIDX_W-1:0] idx;
    logic [DATA_W-1:0] data;
  } rf_wr_t;

  // Data memory write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

endpackage

[sv/vie_if.sv]
// Handshake interfaces for the instruction and result channels.
interface vie_instr_if;
  logic        valid;
  logic        ready;
  logic [15:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface vie_result_if;
  logic       valid;
  logic       ready;
  logic       halted;
  logic       jump_taken;
  logic [7:0] jump_target;
  logic       screen_valid;
  logic [7:0] screen_value;
  logic       bad_opcode;
  logic       reg_written;
  logic [3:0] reg_index;
  logic [7:0] reg_value;

  modport source (
    output valid, output halted, output jump_taken, output jump_target,
    output screen_valid, output screen_value, output bad_opcode,
    output reg_written, output reg_index, output reg_value,
    input ready
  );
  modport sink (
    input valid, input halted, input jump_taken, input jump_target,
    input screen_valid, input screen_value, input bad_opcode,
    input reg_written, input reg_index, input reg_value,
    output ready
  );
endinterface

[sv/vie_regfile.sv]
// Sixteen-entry register file with two registered read ports and a register 0 copy.
module vie_regfile (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [vie_pkg::RIDX_W-1:0]   rd_addr_a_i,
  input  logic [vie_pkg::RIDX_W-1:0]   rd_addr_b_i,
  input  vie_pkg::rf_wr_t              wr_i,
  output logic [vie_pkg::DATA_W-1:0]   rd_data_a_o,
  output logic [vie_pkg::DATA_W-1:0]   rd_data_b_o,
  output logic [vie_pkg::DATA_W-1:0]   r0_o
);

  logic [vie_pkg::DATA_W-1:0]    rf_q [vie_pkg::REG_COUNT];
  logic [vie_pkg::REG_COUNT-1:0] vld_q;
  logic [vie_pkg::DATA_W-1:0]    r0_q;
  logic [vie_pkg::DATA_W-1:0]    rd_a_q;
  logic [vie_pkg::DATA_W-1:0]    rd_b_q;

  // Valid bits make unwritten entries read as zero after reset; register 0 is mirrored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      r0_q  <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_i.idx] <= 1'b1;
      if (wr_i.idx == '0) begin
        r0_q <= wr_i.data;
      end
    end
  end

  // Storage array; a read in the same cycle as a write to that entry sees the new data.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      rf_q[wr_i.idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      if (wr_i.en && (wr_i.idx == rd_addr_a_i)) begin
        rd_a_q <= wr_i.data;
      end else begin
        rd_a_q <= vld_q[rd_addr_a_i] ? rf_q[rd_addr_a_i] : '0;
      end
      if (wr_i.en && (wr_i.idx == rd_addr_b_i)) begin
        rd_b_q <= wr_i.data;
      end else begin
        rd_b_q <= vld_q[rd_addr_b_i] ? rf_q[rd_addr_b_i] : '0;
      end
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;
  assign r0_o        = r0_q;

endmodule

[sv/vie_data_mem.sv]
// Byte-wide main memory with one registered read port and wrapping addresses.
module vie_data_mem #(
  parameter int unsigned MEM_DEPTH = vie_pkg::MEM_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         rd_en_i,
  input  logic [vie_pkg::ADDR_W-1:0]   rd_addr_i,
  input  vie_pkg::mem_wr_t             wr_i,
  output logic [vie_pkg::DATA_W-1:0]   rd_data_o
);

  localparam int unsigned AW        = $clog2(MEM_DEPTH);
  localparam int unsigned LUT_DEPTH = 2 ** vie_pkg::ADDR_W;

  logic [AW-1:0]              addr_lut [LUT_DEPTH];
  logic [vie_pkg::DATA_W-1:0] mem_q [MEM_DEPTH];
  logic [MEM_DEPTH-1:0]       vld_q;
  logic [vie_pkg::DATA_W-1:0] rd_q;
  logic [AW-1:0]              rd_idx;
  logic [AW-1:0]              wr_idx;

  // Constant table folding an 8-bit operand address onto the memory depth.
  for (genvar i = 0; i < LUT_DEPTH; i++) begin : g_addr_lut
    assign addr_lut[i] = AW'(i % MEM_DEPTH);
  end

  assign rd_idx = addr_lut[rd_addr_i];
  assign wr_idx = addr_lut[wr_i.addr];

  // Valid bits make unwritten bytes read as zero after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_i.en) begin
      vld_q[wr_idx] <= 1'b1;
    end
  end

  // Storage array; a read in the same cycle as a write to that byte sees the new data.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      if (wr_i.en && (wr_idx == rd_idx)) begin
        rd_q <= wr_i.data;
      end else begin
        rd_q <= vld_q[rd_idx] ? mem_q[rd_idx] : '0;
      end
    end
  end

  assign rd_data_o = rd_q;

endmodule

[sv/vie_alu.sv]
// Execute logic: decodes one instruction and forms its result and memory write.
module vie_alu (
  input  logic [vie_pkg::INSTR_W-1:0] instr_i,
  input  logic [vie_pkg::DATA_W-1:0]  rd_a_i,
  input  logic [vie_pkg::DATA_W-1:0]  rd_b_i,
  input  logic [vie_pkg::DATA_W-1:0]  r0_i,
  input  logic [vie_pkg::DATA_W-1:0]  mem_data_i,
  output vie_pkg::result_t            result_o,
  output vie_pkg::mem_wr_t            mem_wr_o
);

  // Float byte to a signed value in units of 2^-8.
  function automatic logic signed [12:0] fdecode(input logic [7:0] b);
    logic [11:0] mag;
    mag = 12'(b[3:0]) << b[6:4];
    return b[7] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Signed sum back to a float byte: truncate, clamp the exponent at both ends.
  function automatic logic [7:0] fencode(input logic signed [12:0] s);
    logic        sign;
    logic [12:0] neg;
    logic [11:0] mag;
    logic [3:0]  p;
    logic [2:0]  expo;
    logic [3:0]  mant;
    logic [11:0] shifted;
    sign = s[12];
    neg  = -s;
    mag  = sign ? neg[11:0] : s[11:0];
    p    = '0;
    for (int i = 0; i < 12; i++) begin
      if (mag[i]) begin
        p = 4'(i);
      end
    end
    shifted = mag >> (p - 4'd3);
    if (mag == '0) begin
      return 8'h00;
    end else if (p < 4'd3) begin
      expo = 3'd0;
      mant = mag[3:0];
    end else if (p > 4'd10) begin
      expo = 3'd7;
      mant = 4'hF;
    end else begin
      expo = 3'(p - 4'd3);
      mant = shifted[3:0];
    end
    return {sign, expo, mant};
  endfunction

  vie_pkg::opcode_e           op;
  logic [vie_pkg::RIDX_W-1:0] r_field;
  logic [7:0]                 xy;
  logic [15:0]                rot_word;

  assign op       = vie_pkg::opcode_e'(instr_i[15:12]);
  assign r_field  = instr_i[11:8];
  assign xy       = instr_i[7:0];
  assign rot_word = {rd_a_i, rd_a_i} >> instr_i[2:0];

  // Per-opcode result; every field not set stays zero.
  always_comb begin
    result_o      = '0;
    mem_wr_o      = '0;
    mem_wr_o.addr = xy;
    mem_wr_o.data = rd_a_i;
    result_o.reg_index = r_field;
    case (op)
      vie_pkg::OP_LOAD: begin
        result_o.reg_written = 1'b1;
        result_o.reg_value   = mem_data_i;
      end
      vie_pkg::OP_LOADI: begin
        result_o.reg_written = 1'b1;
        result_o.reg_value   = xy;
      end
      vie_pkg::OP_STORE: begin
        mem_wr_o.en = 1'b1;
        if (xy == '0) begin
          result_o.screen_valid = 1'b1;
          result_o.screen_value = rd_a_i;
        end
      end
      vie_pkg::OP_MOVE: begin
        result_o.reg_written = 1'b1;
        result_o.reg_index   = instr_i[3:0];
        result_o.reg_value   = rd_a_i;
      end
      vie_pkg::OP_ADD: begin
        result_o.reg_written = 1'b1;
        result_o.reg_value   = rd_a_i + rd_b_i;
      end
      vie_pkg::OP_FADD: begin
        result_o.reg_written = 1'b1;
        result_o.reg_value   = fencode(fdecode(rd_a_i) + fdecode(rd_b_i));
      end
      vie_pkg::OP_OR: begin
        result_o.reg_written = 1'b1;
        result_o.reg_value   = rd_a_i | rd_b_i;
      end
      vie_pkg::OP_AND: begin
        result_o.reg_written = 1'b1;
        result_o.reg_value   = rd_a_i & rd_b_i;
      end
      vie_pkg::OP_XOR: begin
        result_o.reg_written = 1'b1;
        result_o.reg_value   = rd_a_i ^ rd_b_i;
      end
      vie_pkg::OP_ROT: begin
        result_o.reg_written = 1'b1;
        result_o.reg_value   = rot_word[7:0];
      end
      vie_pkg::OP_JEQ: begin
        if (rd_a_i == r0_i) begin
          result_o.jump_taken  = 1'b1;
          result_o.jump_target = xy;
        end
      end
      vie_pkg::OP_JGT: begin
        if ($signed(rd_a_i) > $signed(r0_i)) begin
          result_o.jump_taken  = 1'b1;
          result_o.jump_target = xy;
        end
      end
      vie_pkg::OP_HALT: begin
        if (instr_i[11:0] == '0) begin
          result_o.halted = 1'b1;
        end else begin
          result_o.bad_opcode = 1'b1;
        end
      end
      default: begin
        result_o.bad_opcode = 1'b1;
      end
    endcase
    if (!result_o.reg_written) begin
      result_o.reg_index = '0;
    end
  end

endmodule

[sv/vole_instruction_executor_unit.sv]
// Top level of the Vole instruction executor: operand read, execute and result stages.
//
//   Channel    Direction  Payload                                Transaction when
//   instr_i    in         instr_word                             valid && ready
//   result_o   out        halted .. reg_value (one per instr)    valid && ready
//
// An instruction waits in the execute register and then moves to the result register,
// from which its result is offered on result_o; while result_o stays ready, one
// instruction a cycle is sustained. Register file and memory reads are registered at
// acceptance, and write-back at the move to the result register is bypassed into those
// reads. Reset clears the valid bits of both stores, so no clearing pass is needed. A
// stall on result_o holds both stages; instr_i stays ready while either has room.
module vole_instruction_executor_unit #(
  parameter int unsigned MEM_DEPTH = vie_pkg::MEM_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  vie_instr_if.sink     instr_i,
  vie_result_if.source  result_o
);

  logic                         in_acc;
  logic                         ex_adv;
  logic                         ex_vld_q;
  logic                         ex_vld_d;
  logic [vie_pkg::INSTR_W-1:0]  ex_instr_q;
  logic                         out_vld_q;
  logic                         out_vld_d;
  vie_pkg::result_t             out_res_q;
  vie_pkg::result_t             ex_res;
  vie_pkg::mem_wr_t             ex_mem_wr;
  vie_pkg::mem_wr_t             mem_wr;
  vie_pkg::rf_wr_t              rf_wr;
  vie_pkg::opcode_e             in_op;
  logic [vie_pkg::RIDX_W-1:0]   rd_addr_a;
  logic [vie_pkg::DATA_W-1:0]   rd_a;
  logic [vie_pkg::DATA_W-1:0]   rd_b;
  logic [vie_pkg::DATA_W-1:0]   r0;
  logic [vie_pkg::DATA_W-1:0]   mem_rd;

  // Handshake and stage advance.
  assign ex_adv        = ex_vld_q && (!out_vld_q || result_o.ready);
  assign instr_i.ready = !ex_vld_q || ex_adv;
  assign in_acc        = instr_i.valid && instr_i.ready;
  assign ex_vld_d      = in_acc || (ex_vld_q && !ex_adv);
  assign out_vld_d     = ex_adv || (out_vld_q && !result_o.ready);

  // Port A reads X for move and the two-operand ALU ops, otherwise R.
  assign in_op = vie_pkg::opcode_e'(instr_i.instr_word[15:12]);
  always_comb begin
    if (in_op inside {[vie_pkg::OP_MOVE:vie_pkg::OP_XOR]}) begin
      rd_addr_a = instr_i.instr_word[7:4];
    end else begin
      rd_addr_a = instr_i.instr_word[11:8];
    end
  end

  // Write-back happens as an instruction moves into the result register.
  assign rf_wr.en   = ex_adv && ex_res.reg_written;
  assign rf_wr.idx  = ex_res.reg_index;
  assign rf_wr.data = ex_res.reg_value;

  always_comb begin
    mem_wr    = ex_mem_wr;
    mem_wr.en = ex_adv && ex_mem_wr.en;
  end

  vie_regfile u_regfile (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_acc),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (instr_i.instr_word[3:0]),
    .wr_i        (rf_wr),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b),
    .r0_o        (r0)
  );

  vie_data_mem #(
    .MEM_DEPTH (MEM_DEPTH)
  ) u_data_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (instr_i.instr_word[7:0]),
    .wr_i      (mem_wr),
    .rd_data_o (mem_rd)
  );

  vie_alu u_alu (
    .instr_i    (ex_instr_q),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b),
    .r0_i       (r0),
    .mem_data_i (mem_rd),
    .result_o   (ex_res),
    .mem_wr_o   (ex_mem_wr)
  );

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      ex_vld_q  <= ex_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ex_instr_q <= instr_i.instr_word;
    end
    if (ex_adv) begin
      out_res_q <= ex_res;
    end
  end

  // Result channel.
  assign result_o.valid        = out_vld_q;
  assign result_o.halted       = out_res_q.halted;
  assign result_o.jump_taken   = out_res_q.jump_taken;
  assign result_o.jump_target  = out_res_q.jump_target;
  assign result_o.screen_valid = out_res_q.screen_valid;
  assign result_o.screen_value = out_res_q.screen_value;
  assign result_o.bad_opcode   = out_res_q.bad_opcode;
  assign result_o.reg_written  = out_res_q.reg_written;
  assign result_o.reg_index    = out_res_q.reg_index;
  assign result_o.reg_value    = out_res_q.reg_value;

endmodule

[tb/vole_instruction_executor_unit_tb.sv]
// Self-checking testbench for the Vole instruction executor: directed rows, then random programs.
module vole_instruction_executor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import vie_pkg::*;

  // Opcodes that the package leaves without a member; all of them are bad opcodes.
  localparam logic [3:0] OP_BAD_0 = 4'h0;
  localparam logic [3:0] OP_BAD_E = 4'hE;
  localparam logic [3:0] OP_BAD_F = 4'hF;

  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 8;

  // How a directed row is checked: by the predictor, or against a result typed in here.
  typedef enum logic [2:0] {
    CHK_PRED,
    CHK_BAD,
    CHK_HALT,
    CHK_REG,
    CHK_SCREEN
  } chk_e;

  typedef struct packed {
    logic [15:0] word;
    chk_e        chk;
    logic [3:0]  idx;
    logic [7:0]  val;
  } dir_row_t;

  // An accepted instruction and the result it should produce.
  typedef struct packed {
    logic [15:0] word;
    result_t     res;
  } pending_t;

  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{{OP_BAD_0, 4'h0, 8'h00}, CHK_BAD,    4'h0, 8'h00},
    '{{OP_HALT,  4'h0, 8'h00}, CHK_HALT,   4'h0, 8'h00},
    '{{OP_HALT,  4'h0, 8'h01}, CHK_BAD,    4'h0, 8'h00},
    '{{OP_BAD_E, 4'h5, 8'hA3}, CHK_BAD,    4'h0, 8'h00},
    '{{OP_BAD_F, 4'hF, 8'hFF}, CHK_BAD,    4'h0, 8'h00},
    '{{OP_LOAD,  4'h0, 8'h00}, CHK_REG,    4'h0, 8'h00},
    '{{OP_LOADI, 4'hF, 8'hFF}, CHK_REG,    4'hF, 8'hFF},
    '{{OP_LOADI, 4'h1, 8'h7F}, CHK_REG,    4'h1, 8'h7F},
    '{{OP_LOADI, 4'h2, 8'h80}, CHK_REG,    4'h2, 8'h80},
    '{{OP_STORE, 4'hF, 8'h00}, CHK_SCREEN, 4'h0, 8'hFF},
    '{{OP_STORE, 4'h1, 8'hFF}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_LOAD,  4'h5, 8'h00}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_ADD,   4'h6, 8'h12}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_ADD,   4'h7, 8'hF1}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_FADD,  4'h8, 8'h11}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_FADD,  4'h9, 8'h1F}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_LOADI, 4'hB, 8'h01}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_FADD,  4'hC, 8'hBB}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_OR,    4'hD, 8'h12}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_AND,   4'hD, 8'h1F}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_XOR,   4'hD, 8'h2F}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_MOVE,  4'hA, 8'h1E}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_ROT,   4'h1, 8'hF3}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_ROT,   4'h2, 8'h08}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_JEQ,   4'h0, 8'hAB}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_JGT,   4'h1, 8'hCD}, CHK_PRED,   4'h0, 8'h00},
    '{{OP_JGT,   4'h2, 8'hEE}, CHK_PRED,   4'h0, 8'h00}
  };

  logic clk_i;
  logic rst_ni;
  int   cycle_count = 0;
  int   err_count = 0;

  // Architectural state of the predictor.
  logic [7:0] arch_reg [16];
  logic [7:0] arch_mem [256];

  pending_t pending_results [$];

  vie_instr_if  instr_if ();
  vie_result_if result_if ();

  vole_instruction_executor_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .instr_i  (instr_if),
    .result_o (result_if)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Cycle counter and run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("vole_instruction_executor_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input logic [15:0] word, input string what,
                                 input int unsigned got, input int unsigned want);
    err_count++;
    if (err_count <= 100)
      $display("[%0t] instr %h: %s got %0h want %0h", $realtime, word, what, got, want);
  endtask

  // Appends an expectation at the tail of the outstanding list.
  task automatic enqueue_expected(input pending_t entry);
    pending_results = {pending_results, entry};
  endtask

  // Idle length: mostly short, now and then long.
  function automatic int idle_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    else if (pick < 93) return $urandom_range(4, 8);
    else return $urandom_range(15, 40);
  endfunction

  // Float byte to a signed fixed-point value in units of 2^-8.
  function automatic int fp_to_fixed(input logic [7:0] b);
    int mag;
    mag = b[3:0];
    mag = mag << b[6:4];
    return b[7] ? -mag : mag;
  endfunction

  // Executes one instruction on the predictor's state and returns its result.
  function automatic result_t execute_vole(input logic [15:0] word);
    result_t    res;
    logic [3:0] r;
    logic [3:0] dst;
    logic [7:0] xy;
    logic [7:0] val;
    logic [15:0] twice;
    bit         wr;
    int         sum;
    int         mag;
    int         msb;
    int         ex;
    int         sh;
    res = '0;
    r   = word[11:8];
    xy  = word[7:0];
    dst = r;
    val = '0;
    wr  = 1'b1;
    case (word[15:12])
      OP_LOAD:  val = arch_mem[xy];
      OP_LOADI: val = xy;
      OP_STORE: begin
        wr = 1'b0;
        arch_mem[xy] = arch_reg[r];
        if (xy == 8'h00) begin
          res.screen_valid = 1'b1;
          res.screen_value = arch_reg[r];
        end
      end
      OP_MOVE: begin
        dst = xy[3:0];
        val = arch_reg[xy[7:4]];
      end
      OP_ADD: val = arch_reg[xy[7:4]] + arch_reg[xy[3:0]];
      OP_FADD: begin
        sum = fp_to_fixed(arch_reg[xy[7:4]]) + fp_to_fixed(arch_reg[xy[3:0]]);
        mag = (sum < 0) ? -sum : sum;
        msb = 0;
        for (int k = 0; k < 12; k++)
          if (mag[k]) msb = k;
        if (sum == 0) begin
          val = 8'h00;
        end else if (msb < 3) begin
          // Below the smallest exponent the mantissa holds the magnitude exactly.
          val = {sum < 0, 3'd0, mag[3:0]};
        end else if (msb > 10) begin
          // Too large: saturate the magnitude and keep the sign.
          val = {sum < 0, 7'h7F};
        end else begin
          ex  = msb - 3;
          sh  = mag >> ex;
          val = {sum < 0, ex[2:0], sh[3:0]};
        end
      end
      OP_OR:  val = arch_reg[xy[7:4]] | arch_reg[xy[3:0]];
      OP_AND: val = arch_reg[xy[7:4]] & arch_reg[xy[3:0]];
      OP_XOR: val = arch_reg[xy[7:4]] ^ arch_reg[xy[3:0]];
      OP_ROT: begin
        // Only the low three bits of the operand give the rotate amount.
        twice = {arch_reg[r], arch_reg[r]} >> xy[2:0];
        val   = twice[7:0];
      end
      OP_JEQ: begin
        wr = 1'b0;
        if (arch_reg[r] == arch_reg[0]) begin
          res.jump_taken  = 1'b1;
          res.jump_target = xy;
        end
      end
      OP_JGT: begin
        wr = 1'b0;
        if ($signed(arch_reg[r]) > $signed(arch_reg[0])) begin
          res.jump_taken  = 1'b1;
          res.jump_target = xy;
        end
      end
      OP_HALT: begin
        wr = 1'b0;
        if (word[11:0] == 12'h000) res.halted = 1'b1;
        else res.bad_opcode = 1'b1;
      end
      default: begin
        wr = 1'b0;
        res.bad_opcode = 1'b1;
      end
    endcase
    if (wr) begin
      arch_reg[dst]   = val;
      res.reg_written = 1'b1;
      res.reg_index   = dst;
      res.reg_value   = val;
    end
    return res;
  endfunction

  // Random instruction, weighted towards working programs, with some noise.
  function automatic logic [15:0] random_instr();
    int unsigned pick;
    int unsigned bits;
    logic [3:0]  op;
    logic [11:0] low;
    bits = $urandom();
    low  = bits[11:0];
    pick = $urandom_range(0, 99);
    if (pick < 14) op = OP_LOADI;
    else if (pick < 22) op = OP_LOAD;
    else if (pick < 32) op = OP_STORE;
    else if (pick < 38) op = OP_MOVE;
    else if (pick < 46) op = OP_ADD;
    else if (pick < 58) op = OP_FADD;
    else if (pick < 62) op = OP_OR;
    else if (pick < 66) op = OP_AND;
    else if (pick < 70) op = OP_XOR;
    else if (pick < 77) op = OP_ROT;
    else if (pick < 83) op = OP_JEQ;
    else if (pick < 89) op = OP_JGT;
    else if (pick < 92) begin
      op  = OP_HALT;
      low = '0;
    end
    else if (pick < 94) op = OP_HALT;
    else if (pick < 96) op = OP_BAD_0;
    else if (pick < 98) op = OP_BAD_E;
    else op = OP_BAD_F;
    // A narrow address window lets loads find earlier stores, address 00 included.
    if ((op == OP_LOAD || op == OP_STORE) && bits[31:30] != 2'b00)
      low[7:0] = {4'h0, bits[15:12]};
    // Small immediates make equal registers, and so taken jumps, common.
    if (op == OP_LOADI && bits[29])
      low[7:0] = {6'h00, bits[17:16]};
    return {op, low};
  endfunction

  // Sender gap; no gaps at all inside calm stretches.
  function automatic int sender_gap(input int n);
    if ((n % 200) < 40) return 0;
    return $urandom_range(0, 1) ? 0 : idle_len();
  endfunction

  // Presents one instruction after a gap and returns at the edge that accepts it.
  task automatic send_instr(input logic [15:0] word, input int gap);
    if (gap > 0) begin
      instr_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    instr_if.valid      <= 1'b1;
    instr_if.instr_word <= word;
    do @(posedge clk_i); while (!instr_if.ready);
  endtask

  // Result sink: runs of ready broken by stalls, with calm stretches free of stalls.
  initial begin : result_sink
    int stall;
    result_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    result_if.ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      stall = ((cycle_count / 400) % 4 == 0) ? 0 : idle_len();
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        result_if.ready <= 1'b1;
      end
    end
  end

  // Compares each result transaction with the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t  got;
    pending_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = {result_if.halted, result_if.jump_taken, result_if.jump_target,
             result_if.screen_valid, result_if.screen_value, result_if.bad_opcode,
             result_if.reg_written, result_if.reg_index, result_if.reg_value};
      if (pending_results.size() == 0) begin
        report_mismatch(16'h0000, "result with nothing outstanding", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.halted !== want.res.halted)
          report_mismatch(want.word, "halted", got.halted, want.res.halted);
        if (got.jump_taken !== want.res.jump_taken)
          report_mismatch(want.word, "jump_taken", got.jump_taken, want.res.jump_taken);
        if (got.jump_target !== want.res.jump_target)
          report_mismatch(want.word, "jump_target", got.jump_target, want.res.jump_target);
        if (got.screen_valid !== want.res.screen_valid)
          report_mismatch(want.word, "screen_valid", got.screen_valid, want.res.screen_valid);
        if (got.screen_value !== want.res.screen_value)
          report_mismatch(want.word, "screen_value", got.screen_value, want.res.screen_value);
        if (got.bad_opcode !== want.res.bad_opcode)
          report_mismatch(want.word, "bad_opcode", got.bad_opcode, want.res.bad_opcode);
        if (got.reg_written !== want.res.reg_written)
          report_mismatch(want.word, "reg_written", got.reg_written, want.res.reg_written);
        if (got.reg_index !== want.res.reg_index)
          report_mismatch(want.word, "reg_index", got.reg_index, want.res.reg_index);
        if (got.reg_value !== want.res.reg_value)
          report_mismatch(want.word, "reg_value", got.reg_value, want.res.reg_value);
      end
    end
  end

  // Reset, directed rows, random programs and the final verdict.
  initial begin : stimulus
    pending_t item;
    for (int i = 0; i < 16; i++) arch_reg[i] = '0;
    for (int i = 0; i < 256; i++) arch_mem[i] = '0;
    rst_ni              <= 1'b0;
    instr_if.valid      <= 1'b0;
    instr_if.instr_word <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows; typed results replace the prediction where given.
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_instr(DIRECTED[i].word, sender_gap(i + 100));
      item.word = DIRECTED[i].word;
      item.res  = execute_vole(DIRECTED[i].word);
      if (DIRECTED[i].chk != CHK_PRED) item.res = '0;
      case (DIRECTED[i].chk)
        CHK_BAD:  item.res.bad_opcode = 1'b1;
        CHK_HALT: item.res.halted = 1'b1;
        CHK_REG: begin
          item.res.reg_written = 1'b1;
          item.res.reg_index   = DIRECTED[i].idx;
          item.res.reg_value   = DIRECTED[i].val;
        end
        CHK_SCREEN: begin
          item.res.screen_valid = 1'b1;
          item.res.screen_value = DIRECTED[i].val;
        end
        default: ;
      endcase
      enqueue_expected(item);
    end

    // Random programs.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        // Hold off until every outstanding result has drained.
        instr_if.valid <= 1'b0;
        do @(posedge clk_i); while (pending_results.size() != 0);
      end
      item.word = random_instr();
      send_instr(item.word, sender_gap(n));
      item.res = execute_vole(item.word);
      enqueue_expected(item);
    end
    instr_if.valid <= 1'b0;

    // Drain and give the verdict.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("vole_instruction_executor_unit_tb: PASS");
    else
      $display("vole_instruction_executor_unit_tb: FAIL");
    $finish;
  end

endmodule

[sim.f]
sv/vie_pkg.sv
sv/vie_if.sv
sv/vie_regfile.sv
sv/vie_data_mem.sv
sv/vie_alu.sv
sv/vole_instruction_executor_unit.sv
tb/vole_instruction_executor_unit_tb.sv
